@@ rtl/yrs_pkg.sv @@
// Package for the rotate/scale/convert pixel engine: microcode types,
// control word layout, register indexes and the microprogram table.
// No dependencies.
`default_nettype none

package yrs_pkg;

  // Datapath widths.
  localparam int DIM_W   = 12;
  localparam int STR_W   = 13;
  localparam int QUOT_W  = 24;
  localparam int CNT_W   = $clog2(QUOT_W);
  localparam int LUMA_W  = 25;
  localparam int CHR_W   = 24;
  localparam int STEP_W  = 4;
  localparam int CIDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_SRC_W  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_SRC_H  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_DST_W  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_DST_H  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_LSTR   = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_CSTR   = 3'd5;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_LOAD_X,
    OP_DIV,
    OP_SAVE_X,
    OP_SAVE_Y,
    OP_LUMA,
    OP_EMIT_LOC,
    OP_CMUL,
    OP_EMIT_CONV
  } yrs_op_t;

  // Conditions that keep the sequencer on its current step.
  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_DIV,
    HOLD_OUT
  } yrs_hold_t;

  // Branch conditions taken once the step is released.
  typedef enum logic [1:0] {
    BR_NONE,
    BR_ALWAYS,
    BR_MODE
  } yrs_br_t;

  typedef struct packed {
    yrs_op_t           op;
    yrs_hold_t         hold;
    yrs_br_t           br;
    logic [STEP_W-1:0] target;
  } yrs_word_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic in_mode;
    logic div_last;
    logic out_full;
  } yrs_status_t;

  // Command from the sequencer to the datapath.
  typedef struct packed {
    yrs_op_t op;
    logic    en;
  } yrs_cmd_t;

  // Step addresses of the microprogram.
  localparam logic [STEP_W-1:0] ST_WAIT      = 4'd0;
  localparam logic [STEP_W-1:0] ST_LOAD_X    = 4'd1;
  localparam logic [STEP_W-1:0] ST_DIV_X     = 4'd2;
  localparam logic [STEP_W-1:0] ST_SAVE_X    = 4'd3;
  localparam logic [STEP_W-1:0] ST_DIV_Y     = 4'd4;
  localparam logic [STEP_W-1:0] ST_SAVE_Y    = 4'd5;
  localparam logic [STEP_W-1:0] ST_LUMA      = 4'd6;
  localparam logic [STEP_W-1:0] ST_EMIT_LOC  = 4'd7;
  localparam logic [STEP_W-1:0] ST_CMUL      = 4'd8;
  localparam logic [STEP_W-1:0] ST_EMIT_CONV = 4'd9;

  // Microprogram table. Locate runs steps 1 to 7, convert steps 8 and 9.
  function automatic yrs_word_t yrs_rom(input logic [STEP_W-1:0] step);
    yrs_word_t w;
    w = '{op: OP_NOP, hold: HOLD_NONE, br: BR_ALWAYS, target: ST_WAIT};
    unique case (step)
      ST_WAIT:      w = '{op: OP_LATCH,     hold: HOLD_IN,   br: BR_MODE,   target: ST_CMUL};
      ST_LOAD_X:    w = '{op: OP_LOAD_X,    hold: HOLD_NONE, br: BR_NONE,   target: ST_WAIT};
      ST_DIV_X:     w = '{op: OP_DIV,       hold: HOLD_DIV,  br: BR_NONE,   target: ST_WAIT};
      ST_SAVE_X:    w = '{op: OP_SAVE_X,    hold: HOLD_NONE, br: BR_NONE,   target: ST_WAIT};
      ST_DIV_Y:     w = '{op: OP_DIV,       hold: HOLD_DIV,  br: BR_NONE,   target: ST_WAIT};
      ST_SAVE_Y:    w = '{op: OP_SAVE_Y,    hold: HOLD_NONE, br: BR_NONE,   target: ST_WAIT};
      ST_LUMA:      w = '{op: OP_LUMA,      hold: HOLD_NONE, br: BR_NONE,   target: ST_WAIT};
      ST_EMIT_LOC:  w = '{op: OP_EMIT_LOC,  hold: HOLD_OUT,  br: BR_ALWAYS, target: ST_WAIT};
      ST_CMUL:      w = '{op: OP_CMUL,      hold: HOLD_NONE, br: BR_NONE,   target: ST_WAIT};
      ST_EMIT_CONV: w = '{op: OP_EMIT_CONV, hold: HOLD_OUT,  br: BR_ALWAYS, target: ST_WAIT};
      default:      w = '{op: OP_NOP,       hold: HOLD_NONE, br: BR_ALWAYS, target: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/yuv420_rotate_scale_to_rgb_unit.sv @@
// Top level: config registers, destination counters, shared multiplier,
// color converter and output register. Uses yrs_pkg, yrs_sequencer, yrs_divider.
// Locate beat: two divisions through the one radix-2 divider, then the luma step and the
// emit step; the next beat is taken only after the emit. Convert beat: samples latched,
// coefficient products registered, then emit. A result held by m_tready stalls only
// the next emit step. Synchronous reset restores register defaults, zeroes both counters.
`default_nettype none

module yuv420_rotate_scale_to_rgb_unit
  import yrs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // Configuration write port.
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [STR_W-1:0]  cfg_data,
  // Input stream.
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [23:0]       s_tdata,  // luma_sample, cb_sample, cr_sample
  input  wire logic              s_tuser,  // mode
  // Output stream.
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [103:0]      m_tdata,  // pixel_col, pixel_row, luma_offset,
                                           // chroma_offset, blue, green, red, pad
  output logic                   m_tlast   // frame_done
);

  // Configuration registers.
  logic [DIM_W-1:0] src_w, src_h, dst_w, dst_h;
  logic [STR_W-1:0] luma_str, chroma_str;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w      <= DIM_W'(640);
      src_h      <= DIM_W'(480);
      dst_w      <= DIM_W'(450);
      dst_h      <= DIM_W'(600);
      luma_str   <= STR_W'(640);
      chroma_str <= STR_W'(320);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_W: src_w      <= cfg_data[DIM_W-1:0];
        CFG_SRC_H: src_h      <= cfg_data[DIM_W-1:0];
        CFG_DST_W: dst_w      <= cfg_data[DIM_W-1:0];
        CFG_DST_H: dst_h      <= cfg_data[DIM_W-1:0];
        CFG_LSTR:  luma_str   <= cfg_data;
        CFG_CSTR:  chroma_str <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer.
  yrs_status_t status;
  yrs_cmd_t    cmd;
  logic        out_full;
  logic        div_last;

  assign status.in_valid = s_tvalid;
  assign status.in_mode  = s_tuser;
  assign status.div_last = div_last;
  assign status.out_full = out_full;

  yrs_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // No beat is taken while reset is held.
  assign s_tready = !rst && (cmd.op == OP_LATCH);

  // Destination position and its edge tests.
  logic [DIM_W-1:0] row, col;
  logic             col_more;
  logic             last_col, last_row;
  logic [DIM_W-1:0] rev;

  assign col_more = ({1'b0, col} + (DIM_W+1)'(1)) < {1'b0, dst_w};
  assign last_col = !col_more;
  assign last_row = ({1'b0, row} + (DIM_W+1)'(1)) >= {1'b0, dst_h};
  assign rev      = col_more ? (dst_w - DIM_W'(1) - col) : '0;

  // Shared multiplier; its operands follow the current step.
  logic [QUOT_W-1:0]       mul_a;
  logic [STR_W-1:0]        mul_b;
  logic [QUOT_W+STR_W-1:0] mul_full;
  logic [QUOT_W-1:0]       div_quot;
  logic [QUOT_W-1:0]       sx, sy;

  always_comb begin
    unique case (cmd.op)
      OP_LOAD_X: begin
        mul_a = QUOT_W'(row);
        mul_b = STR_W'(src_w);
      end
      OP_SAVE_X: begin
        mul_a = QUOT_W'(rev);
        mul_b = STR_W'(src_h);
      end
      OP_SAVE_Y: begin
        mul_a = div_quot;
        mul_b = luma_str;
      end
      OP_LUMA: begin
        mul_a = {1'b0, sy[QUOT_W-1:1]};
        mul_b = chroma_str;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // Divider: x quotient over dst_height, then y quotient over dst_width.
  logic div_load;
  logic div_step;

  assign div_load = cmd.en && (cmd.op == OP_LOAD_X || cmd.op == OP_SAVE_X);
  assign div_step = (cmd.op == OP_DIV);

  yrs_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .load (div_load),
    .step (div_step),
    .num  (mul_full[QUOT_W-1:0]),
    .den  ((cmd.op == OP_LOAD_X) ? dst_h : dst_w),
    .quot (div_quot),
    .last (div_last)
  );

  // Locate datapath registers.
  logic [LUMA_W-1:0] prod;
  logic [LUMA_W-1:0] luma_off;
  logic [CHR_W-1:0]  chroma_off;

  assign chroma_off = prod[CHR_W-1:0] + CHR_W'(sx[QUOT_W-1:1]);

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      case (cmd.op)
        OP_SAVE_X: sx <= div_quot;
        OP_SAVE_Y: begin
          sy   <= div_quot;
          prod <= mul_full[LUMA_W-1:0];
        end
        OP_LUMA: begin
          luma_off <= prod + LUMA_W'(sx);
          prod     <= mul_full[LUMA_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Convert datapath: centered samples and registered coefficient products.
  logic [7:0]         y_s, u_s, v_s;
  logic signed [8:0]  c_t, d_t, e_t;
  logic signed [17:0] p_yc, p_bu;
  logic signed [14:0] p_gu;
  logic signed [15:0] p_gv;
  logic signed [16:0] p_rv;
  logic signed [19:0] sum_b, sum_g, sum_r;

  assign c_t = $signed({1'b0, y_s}) - 9'sd16;
  assign d_t = $signed({1'b0, u_s}) - 9'sd128;
  assign e_t = $signed({1'b0, v_s}) - 9'sd128;

  always_ff @(posedge clk) begin
    if (cmd.en && cmd.op == OP_LATCH) begin
      y_s <= s_tdata[7:0];
      u_s <= s_tdata[15:8];
      v_s <= s_tdata[23:16];
    end
    if (cmd.op == OP_CMUL) begin
      p_yc <= c_t * 18'sd298;
      p_bu <= d_t * 18'sd516;
      p_gu <= d_t * 15'sd100;
      p_gv <= e_t * 16'sd208;
      p_rv <= e_t * 17'sd409;
    end
  end

  assign sum_b = p_yc + p_bu + 20'sd128;
  assign sum_g = p_yc - p_gu - p_gv + 20'sd128;
  assign sum_r = p_yc + p_rv + 20'sd128;

  // Arithmetic shift right by eight, then clamp to a byte.
  function automatic logic [7:0] shift_clamp(input logic signed [19:0] x);
    logic signed [11:0] q;
    q = 12'(x >>> 8);
    if (q < 0) begin
      return 8'd0;
    end else if (q > 12'sd255) begin
      return 8'd255;
    end
    return q[7:0];
  endfunction

  // Output register and destination counters.
  logic [DIM_W-1:0]  o_col, o_row;
  logic [LUMA_W-1:0] o_luma;
  logic [CHR_W-1:0]  o_chroma;
  logic [7:0]        o_b, o_g, o_r;
  logic              o_last;

  assign out_full = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      row      <= '0;
      col      <= '0;
    end else begin
      // A new result fills the register; otherwise an accepted one leaves it.
      if (cmd.en && (cmd.op == OP_EMIT_LOC || cmd.op == OP_EMIT_CONV)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.en && cmd.op == OP_EMIT_LOC) begin
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : row + DIM_W'(1);
        end else begin
          col <= col + DIM_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en && cmd.op == OP_EMIT_LOC) begin
      o_col    <= col;
      o_row    <= row;
      o_luma   <= luma_off;
      o_chroma <= chroma_off;
      o_b      <= '0;
      o_g      <= '0;
      o_r      <= '0;
      o_last   <= last_col && last_row;
    end else if (cmd.en && cmd.op == OP_EMIT_CONV) begin
      o_col    <= '0;
      o_row    <= '0;
      o_luma   <= '0;
      o_chroma <= '0;
      o_b      <= shift_clamp(sum_b);
      o_g      <= shift_clamp(sum_g);
      o_r      <= shift_clamp(sum_r);
      o_last   <= 1'b0;
    end
  end

  assign m_tdata = {7'd0, o_r, o_g, o_b, o_chroma, o_luma, o_row, o_col};
  assign m_tlast = o_last;

endmodule

`default_nettype wire

@@ rtl/yrs_divider.sv @@
// Restoring radix-2 divider, one quotient bit per cycle while step is high.
// Depends on yrs_pkg for the quotient and divisor widths.
`default_nettype none

module yrs_divider
  import yrs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire logic              step,
  input  wire logic [QUOT_W-1:0] num,
  input  wire logic [DIM_W-1:0]  den,
  output logic      [QUOT_W-1:0] quot,
  output logic                   last
);

  logic [DIM_W-1:0]  rem;
  logic [QUOT_W-1:0] quo;
  logic [DIM_W-1:0]  den_r;
  logic              den_zero;
  logic [CNT_W-1:0]  cnt;
  logic [DIM_W:0]    trial;
  logic [DIM_W:0]    diff;
  logic              ge;

  // One shift-subtract iteration.
  assign trial = {rem, quo[QUOT_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem      <= '0;
      quo      <= num;
      den_r    <= den;
      den_zero <= (den == '0);
    end else if (step) begin
      rem <= ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
      quo <= {quo[QUOT_W-2:0], ge};
    end
  end

  // A zero divisor gives a zero quotient.
  assign quot = den_zero ? '0 : quo;
  assign last = (cnt == CNT_W'(QUOT_W - 1));

endmodule

`default_nettype wire

@@ rtl/yrs_sequencer.sv @@
// Microcode sequencer: step counter, program table lookup, hold and branch.
// Depends on yrs_pkg for the control word and the microprogram.
`default_nettype none

module yrs_sequencer
  import yrs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire yrs_status_t status,
  output yrs_cmd_t         cmd
);

  logic [STEP_W-1:0] pc;
  yrs_word_t         word;
  logic              hold;
  logic              take;

  assign word = yrs_rom(pc);

  // Hold keeps the current step; the enable is raised only when it is released.
  always_comb begin
    unique case (word.hold)
      HOLD_IN:  hold = !status.in_valid;
      HOLD_DIV: hold = !status.div_last;
      HOLD_OUT: hold = status.out_full;
      default:  hold = 1'b0;
    endcase
  end

  always_comb begin
    unique case (word.br)
      BR_ALWAYS: take = 1'b1;
      BR_MODE:   take = status.in_mode;
      default:   take = 1'b0;
    endcase
  end

  assign cmd.op = word.op;
  assign cmd.en = !hold;

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_WAIT;
    end else if (!hold) begin
      pc <= take ? word.target : pc + STEP_W'(1);
    end
  end

endmodule

`default_nettype wire

@@ verif/yrs_pixel_checker.sv @@
// Scoreboard for the rotate/scale/convert pixel engine. It keeps its own copy of the
// registers and destination counters, predicts every result beat and compares it.
// Depends on yrs_pkg for widths and register indexes.
`timescale 1ns / 1ps

module yrs_pixel_checker
  import yrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [STR_W-1:0]  cfg_data,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [23:0]       s_tdata,   // luma_sample, cb_sample, cr_sample
  input  logic              s_tuser,   // mode
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [103:0]      m_tdata,   // pixel_col, pixel_row, luma_offset,
                                       // chroma_offset, blue, green, red, pad
  input  logic              m_tlast,   // frame_done
  output int                errors,
  output int                pending,
  output int                frames
);

  // Register values after reset.
  localparam logic [DIM_W-1:0] SRC_W_RST = 12'd640;
  localparam logic [DIM_W-1:0] SRC_H_RST = 12'd480;
  localparam logic [DIM_W-1:0] DST_W_RST = 12'd450;
  localparam logic [DIM_W-1:0] DST_H_RST = 12'd600;
  localparam logic [STR_W-1:0] LSTR_RST  = 13'd640;
  localparam logic [STR_W-1:0] CSTR_RST  = 13'd320;

  typedef struct packed {
    logic [DIM_W-1:0]  col;
    logic [DIM_W-1:0]  row;
    logic [LUMA_W-1:0] luma;
    logic [CHR_W-1:0]  chroma;
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [7:0]        red;
    logic              last;
  } pixel_beat_t;

  logic [DIM_W-1:0] src_w, src_h, dst_w, dst_h;
  logic [STR_W-1:0] luma_str, chroma_str;
  logic [DIM_W-1:0] row_cnt, col_cnt;

  pixel_beat_t predicted_pixels[$];
  int          err_cnt;
  int          frame_cnt;

  // Arithmetic shift by 8, then clamp into a byte.
  function automatic logic [7:0] clamp_channel(input int acc);
    int q;
    q = acc >>> 8;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  // BT.601 integer conversion of one Y/Cb/Cr triple.
  function automatic pixel_beat_t convert_pixel(input logic [7:0] y, cb, cr);
    int c, d, e;
    pixel_beat_t p;
    c = int'(y) - 16;
    d = int'(cb) - 128;
    e = int'(cr) - 128;
    p       = '0;
    p.blue  = clamp_channel(298 * c + 516 * d + 128);
    p.green = clamp_channel(298 * c - 100 * d - 208 * e + 128);
    p.red   = clamp_channel(298 * c + 409 * e + 128);
    return p;
  endfunction

  // Source offsets of the current destination pixel, then advance the counters.
  // A counter at or past its size counts as the last column or row.
  task automatic locate_pixel(output pixel_beat_t p);
    longint unsigned row, col, rev, sx, sy;
    logic last_col, last_row;
    row = row_cnt;
    col = col_cnt;
    rev = (col + 1 < dst_w) ? dst_w - 1 - col : 0;
    sx  = (dst_h == 0) ? 0 : row * src_w / dst_h;
    sy  = (dst_w == 0) ? 0 : rev * src_h / dst_w;
    last_col = (col + 1 >= dst_w);
    last_row = (row + 1 >= dst_h);
    p        = '0;
    p.col    = col[DIM_W-1:0];
    p.row    = row[DIM_W-1:0];
    p.luma   = LUMA_W'(sy * luma_str + sx);
    p.chroma = CHR_W'((sy >> 1) * chroma_str + (sx >> 1));
    p.last   = last_col && last_row;
    if (last_col) begin
      col_cnt = '0;
      row_cnt = last_row ? '0 : row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
  endtask

  task automatic check_field(input string name, input longint unsigned want, got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Track writes and input beats, compare every output beat with the oldest prediction.
  always @(posedge clk) begin : track
    pixel_beat_t want;
    if (rst) begin
      src_w      = SRC_W_RST;
      src_h      = SRC_H_RST;
      dst_w      = DST_W_RST;
      dst_h      = DST_H_RST;
      luma_str   = LSTR_RST;
      chroma_str = CSTR_RST;
      row_cnt    = '0;
      col_cnt    = '0;
      predicted_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SRC_W: src_w      = cfg_data[DIM_W-1:0];
          CFG_SRC_H: src_h      = cfg_data[DIM_W-1:0];
          CFG_DST_W: dst_w      = cfg_data[DIM_W-1:0];
          CFG_DST_H: dst_h      = cfg_data[DIM_W-1:0];
          CFG_LSTR:  luma_str   = cfg_data;
          CFG_CSTR:  chroma_str = cfg_data;
          default: ;
        endcase
      end

      // tuser high marks a convert beat, low a locate beat.
      if (s_tvalid && s_tready) begin
        if (s_tuser) begin
          want = convert_pixel(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
        end else begin
          locate_pixel(want);
        end
        predicted_pixels.push_back(want);
      end

      if (m_tvalid && m_tready) begin
        if (predicted_pixels.size() == 0) begin
          $error("result beat arrived with no prediction waiting");
          err_cnt++;
        end else begin
          want = predicted_pixels.pop_front();
          check_field("pixel_col",     want.col,    m_tdata[11:0]);
          check_field("pixel_row",     want.row,    m_tdata[23:12]);
          check_field("luma_offset",   want.luma,   m_tdata[48:24]);
          check_field("chroma_offset", want.chroma, m_tdata[72:49]);
          check_field("blue",          want.blue,   m_tdata[80:73]);
          check_field("green",         want.green,  m_tdata[88:81]);
          check_field("red",           want.red,    m_tdata[96:89]);
          check_field("frame_done",    want.last,   m_tlast);
          if (want.last) frame_cnt++;
        end
      end
    end
    errors  <= err_cnt;
    pending <= predicted_pixels.size();
    frames  <= frame_cnt;
  end

endmodule

@@ verif/tb_yuv420_rotate_scale_to_rgb_unit.sv @@
// Testbench top for the rotate/scale/convert pixel engine: clock, reset, register
// writes, input beats and output back-pressure, plus the final verdict.
// Depends on yrs_pkg, the engine RTL and yrs_pixel_checker.
`timescale 1ns / 1ps

module tb_yuv420_rotate_scale_to_rgb_unit
  import yrs_pkg::*;
();

  localparam logic MODE_LOCATE  = 1'b0;
  localparam logic MODE_CONVERT = 1'b1;
  localparam int   STALL_LIMIT   = 4000;
  localparam int   DRAIN_CYCLES  = 64;
  localparam int   RANDOM_PHASES = 12;
  localparam int   PHASE_ITEMS   = 148;

  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_style_t;

  logic              clk;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [STR_W-1:0]  cfg_data  = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata   = '0;   // luma_sample, cb_sample, cr_sample
  logic              s_tuser   = 1'b0; // mode
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [103:0]      m_tdata;          // pixel_col, pixel_row, luma_offset,
                                       // chroma_offset, blue, green, red, pad
  logic              m_tlast;          // frame_done

  int        errors, pending, frames;
  int        burst_left, gap_max;
  bit        steady;
  int        n_locate, n_convert, n_cfg;
  int        rx_tick;
  rx_style_t rx_style = RX_OPEN;
  int        idle_cycles;

  yuv420_rotate_scale_to_rgb_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  yrs_pixel_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .errors    (errors),
    .pending   (pending),
    .frames    (frames)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Output back-pressure: a random style, picked anew as rx_tick advances; one of them never stalls.
  always @(posedge clk) begin
    if (rx_tick % 256 == 0) rx_style = rx_style_t'($urandom_range(0, 3));
    rx_tick++;
    case (rx_style)
      RX_OPEN:     m_tready <= 1'b1;
      RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: m_tready <= (rx_tick % 9) < 2;
      default:     m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog: ends the run when no beat or write has moved for too long.
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $error("no beat moved for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one input beat and hold it until accepted; gaps follow each burst unless steady is set.
  task automatic send_beat(input logic mode, input logic [7:0] y, cb, cr);
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {cr, cb, y};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (mode == MODE_CONVERT) n_convert++;
    else n_locate++;
    if (!steady && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(0, 23);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic wait_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CIDX_W-1:0] idx, input logic [STR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    n_cfg++;
  endtask

  task automatic set_geometry(input logic [STR_W-1:0] sw, sh, dw, dh, ls, cs);
    set_reg(CFG_SRC_W, sw);
    set_reg(CFG_SRC_H, sh);
    set_reg(CFG_DST_W, dw);
    set_reg(CFG_DST_H, dh);
    set_reg(CFG_LSTR, ls);
    set_reg(CFG_CSTR, cs);
    cfg_we <= 1'b0;
  endtask

  // Source sizes: extremes, zero, values with the unused top bit set, or anything.
  function automatic logic [STR_W-1:0] pick_src();
    case ($urandom_range(0, 9))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'd4095;
      3:       return 13'($urandom_range(0, 8191));
      default: return 13'($urandom_range(1, 4095));
    endcase
  endfunction

  // Destination sizes stay small most of the time so frames wrap often.
  function automatic logic [STR_W-1:0] pick_dst();
    case ($urandom_range(0, 19))
      0:       return 13'd0;
      1:       return 13'd4095;
      2, 3:    return 13'($urandom_range(0, 8191));
      default: return 13'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [STR_W-1:0] pick_stride();
    case ($urandom_range(0, 9))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'd8191;
      default: return 13'($urandom_range(1, 8191));
    endcase
  endfunction

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int sent;
    steady     = 1'b0;
    gap_max    = 3;
    burst_left = $urandom_range(0, 5);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry: conversions at the sample extremes, then the first locates.
    send_beat(MODE_CONVERT, 8'd0,   8'd0,   8'd0);
    send_beat(MODE_CONVERT, 8'd255, 8'd255, 8'd255);
    send_beat(MODE_CONVERT, 8'd16,  8'd128, 8'd128);
    send_beat(MODE_CONVERT, 8'd255, 8'd0,   8'd255);
    send_beat(MODE_CONVERT, 8'd0,   8'd255, 8'd0);
    send_beat(MODE_CONVERT, 8'd235, 8'd16,  8'd240);
    repeat (3) send_beat(MODE_LOCATE, 8'd0, 8'd0, 8'd0);

    // Zero output sizes: both quotients fall back to zero, and the column counter
    // already sits past the width, so every locate ends the frame.
    wait_results();
    set_geometry(13'd640, 13'd480, 13'd0, 13'd0, 13'd640, 13'd320);
    repeat (2) send_beat(MODE_LOCATE, 8'hFF, 8'hFF, 8'hFF);

    // One-column output walks the row counter up to ten.
    wait_results();
    set_geometry(13'd4095, 13'd4095, 13'd1, 13'd4095, 13'd8191, 13'd8191);
    repeat (10) send_beat(MODE_LOCATE, 8'd0, 8'd0, 8'd0);

    // Shrink the height under that row: large horizontal offsets overflow both
    // plane offsets, and the row counts as the last one.
    wait_results();
    set_geometry(13'd4095, 13'd4095, 13'd4095, 13'd1, 13'd8191, 13'd8191);
    repeat (2) send_beat(MODE_LOCATE, 8'd0, 8'd0, 8'd0);
    wait_results();
    set_reg(CFG_DST_W, 13'd2);
    cfg_we <= 1'b0;
    send_beat(MODE_LOCATE, 8'd0, 8'd0, 8'd0);

    // Random phases: mostly locate/convert pairs, some stray beats of either kind.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_results();
      set_geometry(pick_src(), pick_src(), pick_dst(), pick_dst(),
                   pick_stride(), pick_stride());
      steady  = ($urandom_range(0, 3) == 0);
      gap_max = $urandom_range(1, 8);
      sent    = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) != 0) begin
          send_beat(MODE_LOCATE, 8'($urandom), 8'($urandom), 8'($urandom));
          send_beat(MODE_CONVERT, pick_sample(), pick_sample(), pick_sample());
          sent += 2;
        end else begin
          send_beat($urandom_range(0, 1) ? MODE_CONVERT : MODE_LOCATE,
                    pick_sample(), pick_sample(), pick_sample());
          sent++;
        end
      end
    end

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d locate and %0d convert beats, %0d register writes,",
             n_locate, n_convert, n_cfg);
    $display("and %0d completed frames across %0d geometry settings.",
             frames, RANDOM_PHASES + 5);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
